// ===== rtl/core/tcst_pkg.sv =====
`default_nettype none
package tcst_pkg;

  localparam int unsigned IndexWidth = 10;
  // table depth; the index covers it exactly, so index reduction is the identity
  localparam int unsigned NumConnections = 1024;
  localparam int unsigned TimeoutWidth = 20;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] CfgEstablished = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgClose       = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgInitial     = 2'd2;

  localparam logic [TimeoutWidth-1:0] EstablishedReset = 20'd432000;
  localparam logic [TimeoutWidth-1:0] CloseReset       = 20'd120;
  localparam logic [TimeoutWidth-1:0] InitialReset     = 20'd120;

  typedef enum logic [3:0] {
    StNone        = 4'd0,
    StSynSent     = 4'd1,
    StSynRecv     = 4'd2,
    StEstablished = 4'd3,
    StFinWait     = 4'd4,
    StCloseWait   = 4'd5,
    StLastAck     = 4'd6,
    StTimeWait    = 4'd7,
    StClosed      = 4'd8
  } tcp_state_e;

  typedef enum logic { PhRead, PhWrite } phase_e;

  typedef struct packed {
    logic [IndexWidth-1:0] conn_index;
    logic        new_entry;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  tcp_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] seg_len;
    logic [15:0] window_field;
  } pkt_t;

  typedef struct packed {
    logic [3:0]  conn_state;
    logic        is_reply;
    logic [31:0] tracked_seq;
    logic [31:0] tracked_ack;
    logic [15:0] window_size;
    logic [TimeoutWidth-1:0] timeout_value;
  } res_t;

  // classified item handed from front to back
  typedef struct packed {
    pkt_t        pkt;
    logic        has_seq;
    logic        has_ack;
    logic [31:0] seq_next;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcst_pkt_if.sv =====
`default_nettype none
interface tcst_pkt_if;
  logic valid;
  logic ready;
  tcst_pkg::pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tcst_res_if.sv =====
`default_nettype none
interface tcst_res_if;
  logic valid;
  logic ready;
  tcst_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tcp_connection_state_tracker.sv =====
// TCP connection state tracker.
// pkt_in carries one packet header plus its table index; res_out returns one
// result per packet: the entry state after the update, and whether the packet
// was taken as reply direction.
// Front end classifies headers into a two-entry queue; back end does a
// read-modify-write of the entry memory: a read phase, then an update phase.
// The back end takes a new packet only once the update of the last one is written.
// A packet passes the queue, the read registers and the result register to res_out.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered; write
// only while idle. Index 0 established, 1 close, 2 initial timeout.
// Reset clears control and timeouts to defaults; entry memory is not cleared,
// an entry must be created (new_entry) before it is used.
// When res_out stalls, the result is held, the back end waits, and the queue
// absorbs up to two more packets before pkt_in.ready drops.
`default_nettype none
module tcp_connection_state_tracker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcst_pkt_if.sink  pkt_in,
  tcst_res_if.source res_out,
  input  wire logic cfg_we_i,
  input  wire logic [tcst_pkg::CfgIndexWidth-1:0] cfg_idx_i,
  input  wire logic [tcst_pkg::TimeoutWidth-1:0] cfg_wdata_i
);
  import tcst_pkg::*;

  logic [TimeoutWidth-1:0] est_q, close_q, init_q;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= EstablishedReset;
      close_q <= CloseReset;
      init_q <= InitialReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEstablished: est_q <= cfg_wdata_i;
        CfgClose: close_q <= cfg_wdata_i;
        CfgInitial: init_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tcst_front u_front (
    .clk_i, .rst_ni, .pkt_in,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  tcst_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .est_tmo_i(est_q), .close_tmo_i(close_q), .init_tmo_i(init_q),
    .res_out
  );
endmodule
`default_nettype wire

// ===== rtl/core/tcst_front.sv =====
`default_nettype none
module tcst_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcst_pkt_if.sink  pkt_in,
  output tcst_pkg::cmd_t cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_ready_i
);
  import tcst_pkg::*;

  // two-entry queue of classified packets
  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    cmd.pkt      = pkt_in.data;
    cmd.has_seq  = pkt_in.data.seq_num != 32'd0;
    cmd.has_ack  = pkt_in.data.ack_num != 32'd0;
    cmd.seq_next = pkt_in.data.seq_num + {16'd0, pkt_in.data.seg_len}
                   + {31'd0, pkt_in.data.tcp_flags[0] | pkt_in.data.tcp_flags[2]};
  end

  assign pkt_in.ready = cnt_q != 2'd2;
  assign push = pkt_in.valid && pkt_in.ready;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("pointer mismatch");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/tcst_back.sv =====
`default_nettype none
module tcst_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tcst_pkg::cmd_t cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire logic [tcst_pkg::TimeoutWidth-1:0] est_tmo_i,
  input  wire logic [tcst_pkg::TimeoutWidth-1:0] close_tmo_i,
  input  wire logic [tcst_pkg::TimeoutWidth-1:0] init_tmo_i,
  tcst_res_if.source res_out
);
  import tcst_pkg::*;

  localparam int unsigned EntryWidth = 32 + 32 + 16 + 16 + 4 + 32 + 32 + 16 + TimeoutWidth;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  state;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [TimeoutWidth-1:0] tmo;
  } entry_t;

  logic [EntryWidth-1:0] mem [NumConnections];
  logic [EntryWidth-1:0] rd_data_q;
  phase_e     ph_q, ph_d;
  cmd_t       cmd_q;
  logic [IndexWidth-1:0] addr;
  entry_t     ent, upd;
  res_t       res;
  logic       reply, orig_match, rev_match, syn, ack, fin, rst, wr_en, take;
  logic       out_valid_q;
  res_t       out_q;
  logic [3:0] nst;
  logic [TimeoutWidth-1:0] ntmo;

  // the index spans the table exactly, so it addresses the entry directly
  assign addr = cmd_q.pkt.conn_index;

  assign take = cmd_valid_i && ph_q == PhRead;
  assign cmd_ready_o = take;

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PhRead:  if (cmd_valid_i) ph_d = PhWrite;
      PhWrite: if (!out_valid_q || res_out.ready) ph_d = PhRead;
      default: ph_d = PhRead;
    endcase
  end

  always_comb begin
    ent = rd_data_q;
    if (cmd_q.pkt.new_entry) begin
      ent.src_addr = cmd_q.pkt.src_ip;
      ent.dst_addr = cmd_q.pkt.dst_ip;
      ent.sport = cmd_q.pkt.sport;
      ent.dport = cmd_q.pkt.dport;
      ent.state = StNone;
      ent.seq = '0;
      ent.ack = '0;
      ent.win = '0;
      ent.tmo = init_tmo_i;
    end
    syn = cmd_q.pkt.tcp_flags[0];
    ack = cmd_q.pkt.tcp_flags[1];
    fin = cmd_q.pkt.tcp_flags[2];
    rst = cmd_q.pkt.tcp_flags[3];
    orig_match = cmd_q.pkt.src_ip == ent.src_addr && cmd_q.pkt.dst_ip == ent.dst_addr
              && cmd_q.pkt.sport == ent.sport && cmd_q.pkt.dport == ent.dport;
    rev_match = cmd_q.pkt.src_ip == ent.dst_addr && cmd_q.pkt.dst_ip == ent.src_addr
             && cmd_q.pkt.sport == ent.dport && cmd_q.pkt.dport == ent.sport;
    reply = !orig_match && rev_match;
    nst = ent.state;
    ntmo = ent.tmo;
    case (ent.state)
      StNone: if (syn && !ack) nst = reply ? StSynRecv : StSynSent;
      StSynSent: begin
        if (syn && ack && reply) begin nst = StEstablished; ntmo = est_tmo_i; end
        else if (rst) nst = StClosed;
      end
      StSynRecv: begin
        if (ack && !reply) begin nst = StEstablished; ntmo = est_tmo_i; end
        else if (rst) nst = StClosed;
      end
      StEstablished: begin
        if (fin) nst = reply ? StCloseWait : StFinWait;
        else if (rst) nst = StClosed;
      end
      StFinWait: if (fin && reply) begin nst = StTimeWait; ntmo = close_tmo_i; end
      StCloseWait: if (fin && !reply) nst = StLastAck;
      StLastAck: if (ack && reply) nst = StClosed;
      default: nst = ent.state;
    endcase
    upd = ent;
    upd.state = nst;
    upd.tmo = ntmo;
    if (cmd_q.has_seq) begin
      if (reply) upd.ack = cmd_q.seq_next;
      else upd.seq = cmd_q.seq_next;
    end
    if (!reply && cmd_q.has_ack) upd.ack = cmd_q.pkt.ack_num;
    upd.win = cmd_q.pkt.window_field;
    res.conn_state = upd.state;
    res.is_reply = reply;
    res.tracked_seq = upd.seq;
    res.tracked_ack = upd.ack;
    res.window_size = upd.win;
    res.timeout_value = upd.tmo;
  end

  assign wr_en = ph_q == PhWrite && (!out_valid_q || res_out.ready);

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      rd_data_q <= mem[cmd_i.pkt.conn_index];
    end
    if (wr_en) begin
      mem[addr] <= upd;
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhRead;
      out_valid_q <= 1'b0;
    end else begin
      ph_q <= ph_d;
      if (wr_en) out_valid_q <= 1'b1;
      else if (res_out.ready) out_valid_q <= 1'b0;
    end
  end

  assign res_out.valid = out_valid_q;
  assign res_out.data = out_q;

`ifndef SYNTHESIS
  a_take_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ph_q == PhWrite) else $error("read not followed by update");
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> out_valid_q) else $error("update without result");
  a_no_take_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take && wr_en)) else $error("read and write overlap");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_tcp_connection_state_tracker.sv =====
`default_nettype none
module tb_tcp_connection_state_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import tcst_pkg::*;

  localparam int unsigned Entries = NumConnections;
  localparam int unsigned StallLimit = 5000;
  localparam logic [3:0] FlSyn = 4'b0001;
  localparam logic [3:0] FlAck = 4'b0010;
  localparam logic [3:0] FlFin = 4'b0100;
  localparam logic [3:0] FlRst = 4'b1000;

  typedef struct {
    pkt_t pkt;
    bit   typed;
    res_t want;
  } dir_row_t;

  typedef struct {
    bit   typed;
    res_t want;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_idx_i = CfgEstablished;
  logic [TimeoutWidth-1:0] cfg_wdata_i = '0;

  tcst_pkt_if pkt_if ();
  tcst_res_if res_if ();

  tcp_connection_state_tracker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_in     (pkt_if),
    .res_out    (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow connection table
  logic [31:0] key_sip [Entries];
  logic [31:0] key_dip [Entries];
  logic [15:0] key_sp [Entries];
  logic [15:0] key_dp [Entries];
  tcp_state_e  conn_st [Entries];
  logic [31:0] seq_nxt [Entries];
  logic [31:0] ack_nxt [Entries];
  logic [15:0] win_last [Entries];
  logic [TimeoutWidth-1:0] tmo_held [Entries];
  bit          created [Entries];

  logic [TimeoutWidth-1:0] tmo_est = EstablishedReset;
  logic [TimeoutWidth-1:0] tmo_close = CloseReset;
  logic [TimeoutWidth-1:0] tmo_init = InitialReset;

  res_t  entry_q[$];
  pend_t typed_q[$];
  int unsigned fails = 0;
  bit burst = 1'b0;
  bit hold_req = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned pool[12];

  function automatic res_t track_packet(input pkt_t p);
    int unsigned ix;
    bit syn, ack, fin, rst, rep;
    tcp_state_e st;
    logic [31:0] nxt;
    res_t r;
    ix = int'(p.conn_index);
    syn = p.tcp_flags[0];
    ack = p.tcp_flags[1];
    fin = p.tcp_flags[2];
    rst = p.tcp_flags[3];
    if (p.new_entry) begin
      key_sip[ix] = p.src_ip;
      key_dip[ix] = p.dst_ip;
      key_sp[ix] = p.sport;
      key_dp[ix] = p.dport;
      conn_st[ix] = StNone;
      seq_nxt[ix] = '0;
      ack_nxt[ix] = '0;
      win_last[ix] = '0;
      tmo_held[ix] = tmo_init;
      created[ix] = 1'b1;
    end
    rep = 1'b0;
    // symmetric keys count as original
    if (!(p.src_ip == key_sip[ix] && p.dst_ip == key_dip[ix] &&
          p.sport == key_sp[ix] && p.dport == key_dp[ix]))
      rep = p.src_ip == key_dip[ix] && p.dst_ip == key_sip[ix] &&
            p.sport == key_dp[ix] && p.dport == key_sp[ix];
    st = conn_st[ix];
    case (st)
      StNone: begin
        if (syn && !ack) st = rep ? StSynRecv : StSynSent;
      end
      StSynSent: begin
        if (syn && ack && rep) begin
          st = StEstablished;
          tmo_held[ix] = tmo_est;
        end else if (rst) st = StClosed;
      end
      StSynRecv: begin
        if (ack && !rep) begin
          st = StEstablished;
          tmo_held[ix] = tmo_est;
        end else if (rst) st = StClosed;
      end
      StEstablished: begin
        if (fin) st = rep ? StCloseWait : StFinWait;
        else if (rst) st = StClosed;
      end
      StFinWait: begin
        if (fin && rep) begin
          st = StTimeWait;
          tmo_held[ix] = tmo_close;
        end
      end
      StCloseWait: begin
        if (fin && !rep) st = StLastAck;
      end
      StLastAck: begin
        if (ack && rep) st = StClosed;
      end
      default: ;
    endcase
    conn_st[ix] = st;
    if (p.seq_num != '0) begin
      nxt = p.seq_num + 32'(p.seg_len) + ((syn || fin) ? 32'd1 : 32'd0);
      if (rep) ack_nxt[ix] = nxt;
      else seq_nxt[ix] = nxt;
    end
    if (!rep && p.ack_num != '0) ack_nxt[ix] = p.ack_num;
    win_last[ix] = p.window_field;
    r.conn_state = st;
    r.is_reply = rep;
    r.tracked_seq = seq_nxt[ix];
    r.tracked_ack = ack_nxt[ix];
    r.window_size = win_last[ix];
    r.timeout_value = tmo_held[ix];
    return r;
  endfunction

  // transfers on both channels, seen at the rising edge
  always @(posedge clk_i) begin
    pend_t pd;
    res_t pred, got, want;
    if (pkt_if.valid && pkt_if.ready) begin
      pred = track_packet(pkt_if.data);
      pd = typed_q.pop_front();
      entry_q.push_back(pd.typed ? pd.want : pred);
    end
    if (res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (entry_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        want = entry_q.pop_front();
        if (got.conn_state !== want.conn_state) begin
          $error("conn_state: expected %0d, got %0d", want.conn_state, got.conn_state);
          fails++;
        end
        if (got.is_reply !== want.is_reply) begin
          $error("is_reply: expected %0d, got %0d", want.is_reply, got.is_reply);
          fails++;
        end
        if (got.tracked_seq !== want.tracked_seq) begin
          $error("tracked_seq: expected %h, got %h", want.tracked_seq, got.tracked_seq);
          fails++;
        end
        if (got.tracked_ack !== want.tracked_ack) begin
          $error("tracked_ack: expected %h, got %h", want.tracked_ack, got.tracked_ack);
          fails++;
        end
        if (got.window_size !== want.window_size) begin
          $error("window_size: expected %h, got %h", want.window_size, got.window_size);
          fails++;
        end
        if (got.timeout_value !== want.timeout_value) begin
          $error("timeout_value: expected %0d, got %0d", want.timeout_value,
                 got.timeout_value);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
        (entry_q.size() == 0 && !pkt_if.valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left, calm_left, r;
    stall_left = 0;
    calm_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 120;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        res_if.ready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          res_if.ready <= 1'b1;
        end else if (r < 92) begin
          res_if.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 97) begin
          res_if.ready <= 1'b0;
          stall_left = $urandom_range(10, 40);
        end else begin
          res_if.ready <= 1'b1;
          calm_left = $urandom_range(50, 200);
        end
      end
    end
  end

  task automatic send_pkt(input pkt_t p, input bit typed, input res_t want);
    int unsigned gap, r;
    pend_t pd;
    r = $urandom_range(0, 99);
    gap = (burst || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pd.typed = typed;
    pd.want = want;
    typed_q.push_back(pd);
    pkt_if.valid <= 1'b1;
    pkt_if.data <= p;
    do @(posedge clk_i); while (!pkt_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    pkt_if.valid <= 1'b0;
    wait (entry_q.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_timeouts(input logic [TimeoutWidth-1:0] est,
                                input logic [TimeoutWidth-1:0] cls,
                                input logic [TimeoutWidth-1:0] ini);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgEstablished;
    cfg_wdata_i <= est;
    @(negedge clk_i);
    cfg_idx_i <= CfgClose;
    cfg_wdata_i <= cls;
    @(negedge clk_i);
    cfg_idx_i <= CfgInitial;
    cfg_wdata_i <= ini;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tmo_est = est;
    tmo_close = cls;
    tmo_init = ini;
  endtask

  function automatic res_t mk_res(input tcp_state_e st, input bit rep, input logic [31:0] sq,
                                  input logic [31:0] ak, input logic [15:0] w,
                                  input logic [TimeoutWidth-1:0] t);
    res_t r;
    r.conn_state = st;
    r.is_reply = rep;
    r.tracked_seq = sq;
    r.tracked_ack = ak;
    r.window_size = w;
    r.timeout_value = t;
    return r;
  endfunction

  function automatic pkt_t mk_pkt(input int unsigned ix, input bit nw, input logic [31:0] sip,
                                  input logic [31:0] dip, input logic [15:0] sp,
                                  input logic [15:0] dp, input logic [3:0] fl,
                                  input logic [31:0] sq, input logic [31:0] ak,
                                  input logic [15:0] pl, input logic [15:0] w);
    pkt_t p;
    p.conn_index = ix[IndexWidth-1:0];
    p.new_entry = nw;
    p.src_ip = sip;
    p.dst_ip = dip;
    p.sport = sp;
    p.dport = dp;
    p.tcp_flags = fl;
    p.seq_num = sq;
    p.ack_num = ak;
    p.seg_len = pl;
    p.window_field = w;
    return p;
  endfunction

  function automatic pkt_t random_pkt();
    pkt_t p;
    int unsigned r, ix, d;
    logic [3:0] fl_pick[7] = '{FlSyn, FlSyn | FlAck, FlAck, FlFin | FlAck, FlFin, FlRst, 4'b0};
    r = $urandom_range(0, 99);
    ix = (r < 3) ? $urandom_range(0, Entries - 1) : pool[$urandom_range(0, 11)];
    p = mk_pkt(ix, 1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), 4'b0,
               $urandom, $urandom, 16'd0, 16'($urandom));
    if (r < 10 || !created[ix]) begin
      p.new_entry = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        p.dst_ip = p.src_ip;
        p.dport = p.sport;
      end
    end else begin
      d = $urandom_range(0, 99);
      if (d < 45) begin
        p.src_ip = key_sip[ix];
        p.dst_ip = key_dip[ix];
        p.sport = key_sp[ix];
        p.dport = key_dp[ix];
      end else if (d < 90) begin
        p.src_ip = key_dip[ix];
        p.dst_ip = key_sip[ix];
        p.sport = key_dp[ix];
        p.dport = key_sp[ix];
      end
    end
    p.tcp_flags = ($urandom_range(0, 4) == 0) ? 4'($urandom) : fl_pick[$urandom_range(0, 6)];
    if ($urandom_range(0, 6) == 0) p.seq_num = '0;
    if ($urandom_range(0, 6) == 0) p.ack_num = '0;
    r = $urandom_range(0, 9);
    p.seg_len = (r < 6) ? 16'($urandom_range(0, 1500)) : (r < 7) ? 16'd0 : 16'($urandom);
    return p;
  endfunction

  initial begin
    dir_row_t tab[$];
    dir_row_t row;
    res_t none_res;
    logic [TimeoutWidth-1:0] est_v[5] = '{20'd0, 20'hFFFFF, 20'd1, 20'd0, 20'd0};
    logic [TimeoutWidth-1:0] cls_v[5] = '{20'd0, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0};
    logic [TimeoutWidth-1:0] ini_v[5] = '{20'd0, 20'hFFFFF, 20'd7, 20'd0, 20'hFFFFF};
    logic [31:0] ha, hb;
    none_res = '0;
    ha = 32'h0A00_0001;
    hb = 32'hC0A8_0001;
    pkt_if.valid = 1'b0;
    pkt_if.data = '0;
    for (int i = 0; i < 12; i++) pool[i] = $urandom_range(0, Entries - 1);

    // plain handshake, wrap of the sequence space, close from the original side
    row.typed = 1;
    row.pkt = mk_pkt(0, 1, ha, hb, 1234, 80, FlSyn, 100, 0, 0, 16'hFFFF);
    row.want = mk_res(StSynSent, 0, 101, 0, 16'hFFFF, InitialReset);
    tab.push_back(row);
    row.pkt = mk_pkt(0, 0, hb, ha, 80, 1234, FlSyn | FlAck, 500, 101, 0, 1000);
    row.want = mk_res(StEstablished, 1, 101, 501, 1000, EstablishedReset);
    tab.push_back(row);
    row.typed = 0;
    row.want = none_res;
    row.pkt = mk_pkt(0, 0, ha, hb, 1234, 80, FlAck, 101, 501, 10, 2000);
    tab.push_back(row);
    row.pkt = mk_pkt(0, 0, ha, hb, 1234, 80, FlFin | FlAck, '1, '1, 16'hFFFF, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(0, 0, hb, ha, 80, 1234, FlFin, 7, 0, 0, 5);
    tab.push_back(row);
    row.pkt = mk_pkt(0, 0, ha, hb, 1234, 80, FlRst, 0, 0, 0, 5);
    tab.push_back(row);
    // unrelated tuple on a live entry is taken as original
    row.pkt = mk_pkt(0, 0, 32'h1, 32'h2, 3, 4, 4'hF, 9, 9, 9, 9);
    tab.push_back(row);
    // symmetric key at the top index, all ones
    row.typed = 1;
    row.pkt = mk_pkt(Entries - 1, 1, '1, '1, '1, '1, 4'b0, 0, 0, 0, 16'h00FF);
    row.want = mk_res(StNone, 0, 0, 0, 16'h00FF, InitialReset);
    tab.push_back(row);
    row.typed = 0;
    row.want = none_res;
    row.pkt = mk_pkt(Entries - 1, 0, '1, '1, '1, '1, FlSyn, '1, '1, '1, '1);
    tab.push_back(row);
    row.pkt = mk_pkt(Entries - 1, 0, '1, '1, '1, '1, FlRst, 0, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(Entries - 1, 0, '1, '1, '1, '1, FlRst | FlSyn, 1, 1, 1, 1);
    tab.push_back(row);
    // passive open, close from the reply side
    row.pkt = mk_pkt(512, 1, hb, ha, 443, 5000, FlAck, 0, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(512, 0, ha, hb, 5000, 443, FlSyn, 1000, 0, 0, 100);
    tab.push_back(row);
    row.pkt = mk_pkt(512, 0, hb, ha, 443, 5000, FlAck, 3000, 1001, 0, 200);
    tab.push_back(row);
    row.pkt = mk_pkt(512, 0, ha, hb, 5000, 443, FlFin, 1001, 0, 20, 300);
    tab.push_back(row);
    row.pkt = mk_pkt(512, 0, hb, ha, 443, 5000, FlFin | FlAck, 3000, 1022, 0, 400);
    tab.push_back(row);
    row.pkt = mk_pkt(512, 0, ha, hb, 5000, 443, FlAck, 0, 3001, 0, 500);
    tab.push_back(row);
    // reset out of a half-open and an open connection
    row.pkt = mk_pkt(2, 1, ha, hb, 1, 2, 4'b0, 0, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(2, 0, hb, ha, 2, 1, FlSyn, 77, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(2, 0, hb, ha, 2, 1, FlRst, 0, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(3, 1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, FlSyn, 1, 0, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(3, 0, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, FlSyn | FlAck,
                     8, 2, 0, 0);
    tab.push_back(row);
    row.pkt = mk_pkt(3, 0, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, FlRst, 0, 0, 0, 0);
    tab.push_back(row);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (tab[i]) send_pkt(tab[i].pkt, tab[i].typed, tab[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_timeouts(est_v[ph], cls_v[ph],
                     (ph == 3) ? 20'($urandom) : ini_v[ph]);
      for (int n = 0; n < 300; n++) begin
        if (ph == 1 && n == 20) begin
          hold_req = 1'b1;
          burst = 1'b1;
        end
        if (ph == 1 && n == 40) burst = 1'b0;
        if (ph == 2 && n == 150) begin
          @(negedge clk_i);
          pkt_if.valid <= 1'b0;
          wait (entry_q.size() == 0);
        end
        send_pkt(random_pkt(), 1'b0, none_res);
      end
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/tcst_pkg.sv
rtl/core/tcst_pkt_if.sv
rtl/core/tcst_res_if.sv
rtl/core/tcst_front.sv
rtl/core/tcst_back.sv
rtl/core/tcp_connection_state_tracker.sv
tb/tb_tcp_connection_state_tracker.sv
